FILE: design/tbpc_pkg.sv
// Shared types and constants for the three-button press classifier.
package tbpc_pkg;

	localparam int NUM_BUTTONS = 3;
	localparam int MS_W        = 32;
	localparam int LIMIT_W     = 16;
	localparam int CFG_IDX_W   = 2;

	typedef logic [MS_W-1:0]      ms_t;
	typedef logic [LIMIT_W-1:0]   limit_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Configuration register indexes
	localparam cfg_idx_t CFG_SHORT_LIMIT = 2'd0;
	localparam cfg_idx_t CFG_LONG_LIMIT  = 2'd1;

	localparam limit_t SHORT_LIMIT_RST = 16'd500;
	localparam limit_t LONG_LIMIT_RST  = 16'd2000;

	// Button positions in the held-state arrays
	localparam int BTN_A = 0;
	localparam int BTN_B = 1;
	localparam int BTN_C = 2;

	// One result transaction
	typedef struct packed {
		logic activity_seen;
		logic wake_request;
		logic recenter_request;
		logic calibrate_request;
		logic poweroff_request;
		logic beep_low;
		logic beep_mid;
		logic beep_high;
	} action_t;

endpackage

FILE: design/three_button_press_classifier.sv
// Top level of the three-button press classifier.
//
// Usage: each input transaction carries one sample of the three button levels
// (1 = down), the current millisecond time now_ms and the screen state. The
// block tracks a held flag and press start time per button, and each sample
// yields exactly one result transaction with eight action bits (activity,
// wake, recenter, calibrate, power off and three beep starts), ORed over the
// three buttons. Press edges latch now_ms; release edges measure the held
// time modulo 2^32 against the short and long limits.
// Path: an accepted sample passes the input register, then the result
// register. Throughput: one transaction per cycle while out_stall is low;
// between the registers lie three 32-bit subtract-and-compare paths and
// the release classification. Stall: when the result register is full and
// out_stall is high, a sample waiting in the input register holds and
// in_stall rises; otherwise input is taken whenever in_valid is high.
// Reset: all buttons read as released, limits return to 500 ms and 2000 ms,
// both pipeline stages empty; unknown config indexes are ignored. The user
// writes limits through cfg_we/cfg_index/cfg_data only while no transaction
// is in flight; the block itself does not enforce this.
module three_button_press_classifier (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write port
	input  logic              cfg_we,
	input  tbpc_pkg::cfg_idx_t cfg_index,
	input  tbpc_pkg::limit_t  cfg_data,
	// input channel
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              btn_a_down,
	input  logic              btn_b_down,
	input  logic              btn_c_down,
	input  tbpc_pkg::ms_t     now_ms,
	input  logic              display_on,
	// output channel
	output logic              out_valid,
	input  logic              out_stall,
	output logic              activity_seen,
	output logic              wake_request,
	output logic              recenter_request,
	output logic              calibrate_request,
	output logic              poweroff_request,
	output logic              beep_low,
	output logic              beep_mid,
	output logic              beep_high
);
	import tbpc_pkg::*;

	limit_t short_limit_q;
	limit_t long_limit_q;

	logic                   valid_s1;
	logic [NUM_BUTTONS-1:0] down_s1;
	ms_t                    now_s1;
	logic                   disp_s1;

	logic [NUM_BUTTONS-1:0] held_q;
	ms_t                    start_q [NUM_BUTTONS];

	logic                   out_valid_q;
	action_t                act_q;

	logic                   adv_out;
	logic                   move_s1;
	logic                   take_in;
	logic [NUM_BUTTONS-1:0] press_edge;
	logic [NUM_BUTTONS-1:0] rel_edge;
	logic [NUM_BUTTONS-1:0] lt_short;
	logic [NUM_BUTTONS-1:0] lt_long;
	ms_t                    dur [NUM_BUTTONS];
	action_t                act_d;

	// Flow control: result register frees when empty or taken
	assign adv_out  = !out_valid_q || !out_stall;
	assign move_s1  = valid_s1 && adv_out;
	assign in_stall = valid_s1 && !adv_out;
	assign take_in  = in_valid && !in_stall;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_limit_q <= SHORT_LIMIT_RST;
			long_limit_q  <= LONG_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SHORT_LIMIT: short_limit_q <= cfg_data;
				CFG_LONG_LIMIT:  long_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the input sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			down_s1 <= {btn_c_down, btn_b_down, btn_a_down};
			now_s1  <= now_ms;
			disp_s1 <= display_on;
		end
	end

	// Detect edges and measure held time per button
	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			press_edge[i] = down_s1[i] && !held_q[i];
			rel_edge[i]   = !down_s1[i] && held_q[i];
			dur[i]        = now_s1 - start_q[i];
			lt_short[i]   = dur[i] < {{(MS_W-LIMIT_W){1'b0}}, short_limit_q};
			lt_long[i]    = dur[i] < {{(MS_W-LIMIT_W){1'b0}}, long_limit_q};
		end
	end

	// Classify presses and releases and OR the actions of all buttons
	always_comb begin
		act_d = '0;
		act_d.activity_seen = |press_edge;
		if (rel_edge[BTN_A]) begin
			if (lt_short[BTN_A]) begin
				act_d.activity_seen = 1'b1;
				act_d.wake_request  = !disp_s1;
			end else begin
				act_d.beep_low         = 1'b1;
				act_d.recenter_request = 1'b1;
			end
		end
		if (rel_edge[BTN_B]) begin
			if (lt_long[BTN_B]) begin
				act_d.beep_mid         = 1'b1;
				act_d.recenter_request = 1'b1;
			end else begin
				act_d.calibrate_request = 1'b1;
			end
		end
		if (rel_edge[BTN_C]) begin
			if (lt_short[BTN_C] || lt_long[BTN_C]) begin
				act_d.beep_high     = 1'b1;
				act_d.activity_seen = 1'b1;
				if (!disp_s1) begin
					act_d.wake_request = 1'b1;
				end
			end else begin
				act_d.poweroff_request = 1'b1;
			end
		end
	end

	// Update held state as the sample retires into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				start_q[i] <= '0;
			end
		end else if (move_s1) begin
			held_q <= down_s1;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				if (press_edge[i]) begin
					start_q[i] <= now_s1;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			act_q <= act_d;
		end
	end

	assign out_valid         = out_valid_q;
	assign activity_seen     = act_q.activity_seen;
	assign wake_request      = act_q.wake_request;
	assign recenter_request  = act_q.recenter_request;
	assign calibrate_request = act_q.calibrate_request;
	assign poweroff_request  = act_q.poweroff_request;
	assign beep_low          = act_q.beep_low;
	assign beep_mid          = act_q.beep_mid;
	assign beep_high         = act_q.beep_high;

endmodule

FILE: design/tbpc_checker.sv
// Port-level checker for the three-button press classifier, with its bind.
module tbpc_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic activity_seen,
	input logic wake_request,
	input logic recenter_request,
	input logic calibrate_request,
	input logic poweroff_request,
	input logic beep_low,
	input logic beep_mid,
	input logic beep_high
);
	import tbpc_pkg::*;

	// A stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable({activity_seen, wake_request,
			recenter_request, calibrate_request, poweroff_request, beep_low, beep_mid,
			beep_high}))
		else $error("result changed while stalled");

	// Button B gives either a short or a long release, never both
	a_b_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(calibrate_request && beep_mid))
		else $error("calibrate and mid beep together");

	// Low beep only comes with the button A recenter
	a_low_recenter: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && beep_low |-> recenter_request)
		else $error("low beep without recenter");

	// High beep only comes with activity from button C, and never with power off
	a_high_activity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && beep_high |-> activity_seen && !poweroff_request)
		else $error("high beep without activity or with power off");

endmodule

bind three_button_press_classifier tbpc_checker u_tbpc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.activity_seen     (activity_seen),
	.wake_request      (wake_request),
	.recenter_request  (recenter_request),
	.calibrate_request (calibrate_request),
	.poweroff_request  (poweroff_request),
	.beep_low          (beep_low),
	.beep_mid          (beep_mid),
	.beep_high         (beep_high)
);

FILE: test/tb_three_button_press_classifier.sv
// Testbench for the three-button press classifier: directed and random samples checked against a local predictor.
module tb_three_button_press_classifier;
	timeunit 1ns;
	timeprecision 1ps;

	import tbpc_pkg::*;

	// Indexes that map to no register; writes to them must be ignored
	localparam cfg_idx_t CFG_SPARE_2 = 2'd2;
	localparam cfg_idx_t CFG_SPARE_3 = 2'd3;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     cfg_we = 1'b0;
	cfg_idx_t cfg_index = CFG_SHORT_LIMIT;
	limit_t   cfg_data = '0;
	logic     in_valid = 1'b0;
	logic     in_stall;
	logic     btn_a_down = 1'b0;
	logic     btn_b_down = 1'b0;
	logic     btn_c_down = 1'b0;
	ms_t      now_ms = '0;
	logic     display_on = 1'b0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	logic     activity_seen;
	logic     wake_request;
	logic     recenter_request;
	logic     calibrate_request;
	logic     poweroff_request;
	logic     beep_low;
	logic     beep_mid;
	logic     beep_high;

	// Predictor state: held flags, press start times and the two limits
	bit       btn_held [NUM_BUTTONS];
	ms_t      btn_start [NUM_BUTTONS];
	limit_t   short_lim;
	limit_t   long_lim;

	action_t  action_q [$];
	int       err_count = 0;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	ms_t      clock_ms = '0;

	// Field names by bit position of action_t
	string    action_name [8] = '{"beep_high", "beep_mid", "beep_low", "poweroff_request",
		"calibrate_request", "recenter_request", "wake_request", "activity_seen"};

	three_button_press_classifier DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.btn_a_down        (btn_a_down),
		.btn_b_down        (btn_b_down),
		.btn_c_down        (btn_c_down),
		.now_ms            (now_ms),
		.display_on        (display_on),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.activity_seen     (activity_seen),
		.wake_request      (wake_request),
		.recenter_request  (recenter_request),
		.calibrate_request (calibrate_request),
		.poweroff_request  (poweroff_request),
		.beep_low          (beep_low),
		.beep_mid          (beep_mid),
		.beep_high         (beep_high)
	);

	always #2 clk = ~clk;

	// Stall the result channel at random
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Advance the predictor by one sample and return the ORed actions
	function automatic action_t classify_sample(bit a, bit b, bit c, ms_t now, bit disp);
		action_t  act = '0;
		bit [2:0] level = {c, b, a};
		bit [2:0] released = '0;
		ms_t      held [NUM_BUTTONS];
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			held[i] = '0;
			if (level[i] && !btn_held[i]) begin
				btn_start[i] = now;
				btn_held[i] = 1'b1;
				act.activity_seen = 1'b1;
			end else if (!level[i] && btn_held[i]) begin
				btn_held[i] = 1'b0;
				released[i] = 1'b1;
				held[i] = now - btn_start[i];
			end
		end
		// Button A: short wakes if the display is off, anything else recenters with the low beep
		if (released[BTN_A]) begin
			if (held[BTN_A] < ms_t'(short_lim)) begin
				if (!disp)
					act.wake_request = 1'b1;
				act.activity_seen = 1'b1;
			end else begin
				act.beep_low = 1'b1;
				act.recenter_request = 1'b1;
			end
		end
		// Button B: below long recenters with the mid beep, else calibrates
		if (released[BTN_B]) begin
			if (held[BTN_B] < ms_t'(long_lim)) begin
				act.beep_mid = 1'b1;
				act.recenter_request = 1'b1;
			end else begin
				act.calibrate_request = 1'b1;
			end
		end
		// Button C: below either limit wakes (display off) with the high beep, else powers off
		if (released[BTN_C]) begin
			if (held[BTN_C] < ms_t'(short_lim) || held[BTN_C] < ms_t'(long_lim)) begin
				act.beep_high = 1'b1;
				if (!disp)
					act.wake_request = 1'b1;
				act.activity_seen = 1'b1;
			end else begin
				act.poweroff_request = 1'b1;
			end
		end
		return act;
	endfunction

	// Send one sample transaction, with random idle cycles ahead of it
	task automatic send_sample(bit a, bit b, bit c, ms_t now, bit disp);
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		btn_a_down <= a;
		btn_b_down <= b;
		btn_c_down <= c;
		now_ms     <= now;
		display_on <= disp;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		action_q.push_back(classify_sample(a, b, c, now, disp));
	endtask

	// Hold off the sender until every expected result has arrived
	task automatic drain_results();
		in_valid <= 1'b0;
		while (action_q.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Write one configuration register while the block is idle
	task automatic write_cfg(cfg_idx_t idx, limit_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_SHORT_LIMIT)
			short_lim = val;
		else if (idx == CFG_LONG_LIMIT)
			long_lim = val;
	endtask

	// Random samples: mostly press/release traffic, some aimed at the limits, some noise
	task automatic random_samples(int count);
		bit  lv [NUM_BUTTONS];
		int  mode;
		int  pick;
		for (int k = 0; k < count; k++) begin
			for (int i = 0; i < NUM_BUTTONS; i++)
				lv[i] = btn_held[i] ^ ($urandom_range(99) < 35);
			mode = $urandom_range(99);
			if (mode < 60) begin
				clock_ms = clock_ms + $urandom_range(300);
			end else if (mode < 75) begin
				clock_ms = clock_ms + $urandom_range(3000);
			end else if (mode < 90) begin
				// Aim a release one below, at or one above a limit
				pick = $urandom_range(NUM_BUTTONS - 1);
				clock_ms = btn_start[pick] + ($urandom_range(1) ? ms_t'(short_lim) : ms_t'(long_lim))
					+ $urandom_range(2) - 1;
				lv[pick] = 1'b0;
			end else if (mode < 97) begin
				clock_ms = $urandom;
			end
			send_sample(lv[0], lv[1], lv[2], clock_ms, 1'($urandom_range(1)));
		end
	endtask

	// Every outcome of every button under the reset limits
	task automatic test_each_button();
		send_sample(0, 0, 0, 32'd0, 0);
		send_sample(1, 0, 0, 32'd1000, 0);
		send_sample(0, 0, 0, 32'd1499, 0);
		send_sample(1, 0, 0, 32'd2000, 1);
		send_sample(0, 0, 0, 32'd2500, 1);
		send_sample(0, 1, 0, 32'd3000, 0);
		send_sample(0, 0, 0, 32'd4999, 0);
		send_sample(0, 1, 0, 32'd5000, 0);
		send_sample(0, 0, 0, 32'd7000, 0);
		send_sample(0, 0, 1, 32'd8000, 1);
		send_sample(0, 0, 0, 32'd8100, 1);
		send_sample(0, 0, 1, 32'd9000, 0);
		send_sample(0, 0, 0, 32'd10999, 0);
		send_sample(0, 0, 1, 32'd11000, 0);
		send_sample(0, 0, 0, 32'd13000, 0);
	endtask

	// Steady levels, timestamp wrap and time running backward
	task automatic test_steady_and_wrap();
		send_sample(1, 1, 1, 32'hFFFF_FFF0, 0);
		send_sample(1, 1, 1, 32'hFFFF_FFF8, 0);
		send_sample(0, 0, 0, 32'h0000_0010, 0);
		send_sample(1, 1, 1, 32'hFFFF_FFFF, 1);
		send_sample(0, 0, 0, 32'hFFFF_FFFE, 1);
		send_sample(0, 0, 0, 32'h0000_0000, 1);
	endtask

	// Short limit above long limit, plus ignored writes to spare indexes
	task automatic test_limit_order();
		drain_results();
		write_cfg(CFG_SHORT_LIMIT, 16'd2000);
		write_cfg(CFG_LONG_LIMIT, 16'd500);
		write_cfg(CFG_SPARE_2, 16'hFFFF);
		write_cfg(CFG_SPARE_3, 16'h0000);
		send_sample(1, 1, 1, 32'd20000, 0);
		send_sample(0, 0, 0, 32'd21000, 0);
	endtask

	// Random traffic over several limit settings and idling mixes
	task automatic test_random_traffic();
		limit_t     lim_short [6];
		limit_t     lim_long [6];
		idle_mode_e mode;
		lim_short = '{16'd500, 16'd0, 16'hFFFF, 16'd1800, 16'hFFFF, 16'd0};
		lim_long  = '{16'd2000, 16'd0, 16'hFFFF, 16'd300, 16'd0, 16'd0};
		lim_short[5] = limit_t'($urandom_range(1500));
		lim_long[5]  = limit_t'($urandom_range(3000));
		for (int p = 0; p < 6; p++) begin
			drain_results();
			write_cfg(CFG_SHORT_LIMIT, lim_short[p]);
			write_cfg(CFG_LONG_LIMIT, lim_long[p]);
			write_cfg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, limit_t'($urandom));
			mode = idle_mode_e'(p % 4);
			case (mode)
				IDLE_NONE: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				IDLE_SEND: begin
					send_idle_pct = 63;
					recv_stall_pct = 0;
				end
				IDLE_RECV: begin
					send_idle_pct = 0;
					recv_stall_pct = 63;
				end
				default: begin
					send_idle_pct = 14;
					recv_stall_pct = 14;
				end
			endcase
			random_samples(45);
			drain_results();
			random_samples(45);
		end
	endtask

	// Compare each accepted result with the oldest expectation
	always @(negedge clk) begin
		action_t got;
		action_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {activity_seen, wake_request, recenter_request, calibrate_request,
				poweroff_request, beep_low, beep_mid, beep_high};
			if (action_q.size() == 0) begin
				$display("%0t: result with no expectation waiting, expected none actual %b",
					$time, got);
				err_count++;
			end else begin
				want = action_q.pop_front();
				for (int i = 7; i >= 0; i--) begin
					if (want[i] !== got[i]) begin
						$display("%0t: %s expected %0b actual %0b", $time, action_name[i],
							want[i], got[i]);
						err_count++;
					end
				end
			end
		end
	end

	// Run reset, the tests in turn, then the final verdict
	initial begin
		short_lim = SHORT_LIMIT_RST;
		long_lim  = LONG_LIMIT_RST;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			btn_held[i] = 1'b0;
			btn_start[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_each_button();
		test_steady_and_wrap();
		test_limit_order();
		test_random_traffic();
		drain_results();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// End a hung run
	initial begin
		#2ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: three_button_press_classifier.f
design/tbpc_pkg.sv
design/three_button_press_classifier.sv
design/tbpc_checker.sv
test/tb_three_button_press_classifier.sv
